### rtl/rv32dec_pkg.sv
// ----------------------------------------------------------------------------
// RV32I subset decoder package
// Format, operation and major opcode codes, plus the decode function that
// maps one instruction word to its format, operation and immediate.
// ----------------------------------------------------------------------------
package rv32dec_pkg;

    localparam int WordWidth = 32;

    // format class codes
    localparam logic [2:0] FMT_R       = 3'd0;
    localparam logic [2:0] FMT_I       = 3'd1;
    localparam logic [2:0] FMT_S       = 3'd2;
    localparam logic [2:0] FMT_B       = 3'd3;
    localparam logic [2:0] FMT_U       = 3'd4;
    localparam logic [2:0] FMT_J       = 3'd5;
    localparam logic [2:0] FMT_UNKNOWN = 3'd6;

    // operation codes
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_XOR  = 4'd1;
    localparam logic [3:0] OP_ORI  = 4'd2;
    localparam logic [3:0] OP_SRAI = 4'd3;
    localparam logic [3:0] OP_LB   = 4'd4;
    localparam logic [3:0] OP_LW   = 4'd5;
    localparam logic [3:0] OP_SB   = 4'd6;
    localparam logic [3:0] OP_SW   = 4'd7;
    localparam logic [3:0] OP_BEQ  = 4'd8;
    localparam logic [3:0] OP_LUI  = 4'd9;
    localparam logic [3:0] OP_JAL  = 4'd10;

    // major opcodes
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;

    // funct3 / funct7 values
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_BYTE = 3'd0;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    typedef struct packed {
        logic [2:0]                  fmt;
        logic [3:0]                  op;
        logic                        invalid;
        logic signed [WordWidth-1:0] imm;
    } dec_t;

    function automatic dec_t decode(input logic [WordWidth-1:0] w);
        dec_t       d;
        logic [6:0] opc;
        logic [2:0] f3;
        logic [6:0] f7;
        logic       ok;
        opc     = w[6:0];
        f3      = w[14:12];
        f7      = w[31:25];
        ok      = 1'b0;
        d.fmt   = FMT_UNKNOWN;
        d.op    = OP_ADD;
        d.imm   = '0;
        unique case (opc) inside
            OPC_OP:
            begin
                d.fmt = FMT_R;
                if (f7 == F7_BASE && f3 == F3_ADD)
                begin
                    d.op = OP_ADD;
                    ok   = 1'b1;
                end
                else if (f7 == F7_BASE && f3 == F3_XOR)
                begin
                    d.op = OP_XOR;
                    ok   = 1'b1;
                end
            end
            OPC_OPIMM, OPC_LOAD, OPC_SYSTEM:
            begin
                d.fmt = FMT_I;
                d.imm = {{20{w[31]}}, w[31:20]};
                if (opc == OPC_OPIMM)
                begin
                    if (f3 == F3_OR)
                    begin
                        d.op = OP_ORI;
                        ok   = 1'b1;
                    end
                    else if (f3 == F3_SR && f7 == F7_ALT)
                    begin
                        d.op = OP_SRAI;
                        ok   = 1'b1;
                    end
                end
                else if (opc == OPC_LOAD)
                begin
                    if (f3 == F3_BYTE)
                    begin
                        d.op = OP_LB;
                        ok   = 1'b1;
                    end
                    else if (f3 == F3_WORD)
                    begin
                        d.op = OP_LW;
                        ok   = 1'b1;
                    end
                end
            end
            OPC_STORE:
            begin
                d.fmt = FMT_S;
                d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
                if (f3 == F3_BYTE)
                begin
                    d.op = OP_SB;
                    ok   = 1'b1;
                end
                else if (f3 == F3_WORD)
                begin
                    d.op = OP_SW;
                    ok   = 1'b1;
                end
            end
            OPC_BRANCH:
            begin
                d.fmt = FMT_B;
                d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                if (f3 == F3_BEQ)
                begin
                    d.op = OP_BEQ;
                    ok   = 1'b1;
                end
            end
            OPC_LUI, OPC_AUIPC:
            begin
                d.fmt = FMT_U;
                d.imm = {w[31:12], 12'b0};
                if (opc == OPC_LUI)
                begin
                    d.op = OP_LUI;
                    ok   = 1'b1;
                end
            end
            OPC_JAL:
            begin
                d.fmt = FMT_J;
                d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                d.op  = OP_JAL;
                ok    = 1'b1;
            end
            default:
            begin
                d.fmt = FMT_UNKNOWN;
            end
        endcase
        // unsupported combinations report operation zero
        if (!ok)
        begin
            d.op = OP_ADD;
        end
        d.invalid = ~ok;
        return d;
    endfunction

endpackage

### rtl/rv32i_subset_instruction_decoder.sv
// ----------------------------------------------------------------------------
// RV32I subset instruction decoder
// Two-stage valid/stall pipeline: capture the instruction word, decode it,
// and present format, operation, register fields and immediate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry one instruction word
//   (instr_word). A word is taken on a rising edge with in_valid high and
//   in_stall low.
//   Output channel: out_valid / out_stall carry one decoded result per
//   word: format_class, op_code, op_invalid, dest_reg, src1_reg, src2_reg,
//   func3_field, func7_field and immediate. A result is taken on a rising
//   edge with out_valid high and out_stall low.
//   Path: a word offered on instr_word goes into the input register, then is
//   decoded into the result register and shown on the outputs; out_stall
//   can hold it in the input register between the two.
//   Throughput: one word per cycle while not stalled; decode is a single
//   shallow pass of opcode compare and immediate muxing between registers.
//   Reset: rst_n low empties both stages at once; in_stall is low and
//   out_valid low after reset.
//   Stall: while out_stall holds a full result register, the result stays
//   put, the input register holds its word, and in_stall rises once the
//   input register is full. No word is dropped or repeated.
// ----------------------------------------------------------------------------
module rv32i_subset_instruction_decoder
    import rv32dec_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [WordWidth-1:0]        instr_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  format_class,
    output logic [3:0]                  op_code,
    output logic                        op_invalid,
    output logic [4:0]                  dest_reg,
    output logic [4:0]                  src1_reg,
    output logic [4:0]                  src2_reg,
    output logic [2:0]                  func3_field,
    output logic [6:0]                  func7_field,
    output logic signed [WordWidth-1:0] immediate
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [WordWidth-1:0] in_word_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [WordWidth-1:7] out_word_reg;
    dec_t                 out_dec_reg;
    dec_t                 dec_next;
    logic                 out_adv;
    logic                 in_adv;
    logic                 in_take;

    // result stage moves when empty or drained this cycle
    assign out_adv  = !out_valid_reg || !out_stall;
    assign in_adv   = !in_valid_reg || out_adv;
    assign in_stall = !in_adv;
    assign in_take  = in_valid && in_adv;

    assign in_valid_next  = in_adv ? in_valid : in_valid_reg;
    assign out_valid_next = out_adv ? in_valid_reg : out_valid_reg;

    assign dec_next = decode(in_word_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg <= instr_word;
        end
        if (out_adv && in_valid_reg)
        begin
            out_word_reg <= in_word_reg[WordWidth-1:7];
            out_dec_reg  <= dec_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign format_class = out_dec_reg.fmt;
    assign op_code      = out_dec_reg.op;
    assign op_invalid   = out_dec_reg.invalid;
    assign immediate    = out_dec_reg.imm;
    assign dest_reg     = out_word_reg[11:7];
    assign src1_reg     = out_word_reg[19:15];
    assign src2_reg     = out_word_reg[24:20];
    assign func3_field  = out_word_reg[14:12];
    assign func7_field  = out_word_reg[31:25];

`ifndef NO_ASSERTIONS
    a_fill_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_adv) |=> out_valid_reg)
        else $error("decoded word did not reach result register");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    a_unknown_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !op_invalid) |-> (format_class != FMT_UNKNOWN))
        else $error("valid operation with unknown format");

    a_invalid_op_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && op_invalid) |-> (op_code == OP_ADD))
        else $error("invalid result carries nonzero operation");

    a_r_imm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (format_class == FMT_R || format_class == FMT_UNKNOWN))
            |-> (immediate == '0))
        else $error("immediate nonzero for R or unknown format");
`endif

endmodule
